### sv/utli_pkg.sv
// Shared constants and types for the uniform table interpolator.
package utli_pkg;

    // Table geometry and fraction precision
    localparam int TABLE_DEPTH = 4096;
    localparam int FRAC_BITS   = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    // Field widths fixed by the interface
    localparam int DATA_W   = 32;
    localparam int TIME_W   = 32;
    localparam int INDEX_W  = 12;
    localparam int USED_W   = 13;
    localparam int CFG_IDX_W = 2;

    // Divider geometry: quotient carries the index and the fraction together
    localparam int QUOT_W  = TIME_W + FRAC_BITS;
    localparam int CNT_W   = $clog2(QUOT_W + 1);
    localparam int REM_W   = TIME_W + 1;

    // Product of a 33-bit difference and an unsigned fraction
    localparam int DIFF_W  = DATA_W + 1;
    localparam int PROD_W  = DIFF_W + FRAC_BITS + 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_SPACING = 2'd0,
        CFG_ENTRIES_USED   = 2'd1
    } t_cfg_idx;

    // Item modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [TIME_W-1:0] SPACING_RESET = 32'd65536;

endpackage

### sv/uniform_table_linear_interp.sv
// Top level: sample table, sequencer and interpolation datapath.
//
// Channel   | Direction | Signals                                        | Beat taken when
// ----------+-----------+------------------------------------------------+--------------------
// item      | in        | i_mode i_entry_index i_entry_value i_query_time | start && !busy
// result    | out       | o_kernel_value o_out_of_range                  | o_result_strobe
// config    | in        | i_cfg_index i_cfg_data                         | i_cfg_we
//
// A write beat gives no result; busy stays low.
// A query that fails the entry count or zero spacing check gives its result
// in the next cycle. Any other query runs the 48-step divider, then a
// range check, two reads of the table and one multiply.
// Reset is synchronous and active low; the table keeps its contents.
// The receiver cannot stall: each result is shown for one cycle only.
module uniform_table_linear_interp
    import utli_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_mode,
    input  logic [INDEX_W-1:0]   i_entry_index,
    input  logic signed [DATA_W-1:0] i_entry_value,
    input  logic [TIME_W-1:0]    i_query_time,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIME_W-1:0]    i_cfg_data,
    output logic                 o_result_strobe,
    output logic signed [DATA_W-1:0] o_kernel_value,
    output logic                 o_out_of_range
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_RD0,
        S_RD1,
        S_MUL,
        S_SUM
    } t_state;

    t_state r_state;

    logic [TIME_W-1:0]    r_sample_spacing;
    logic [USED_W-1:0]    r_entries_used;

    logic [DATA_W-1:0]    r_table [TABLE_DEPTH];
    logic [ADDR_W-1:0]    r_rd_addr;
    logic [DATA_W-1:0]    r_rd_data;

    logic [QUOT_W-1:0]    r_quot;
    logic signed [DATA_W-1:0] r_v0;
    logic signed [PROD_W-1:0] r_prod;

    logic                 r_strobe;
    logic                 r_oor;
    logic signed [DATA_W-1:0] r_value;

    logic                 w_accept;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [QUOT_W-1:0]    w_div_quot;
    logic [USED_W-1:0]    w_used;
    logic                 w_bad_cfg;
    logic [TIME_W-1:0]    w_idx;
    logic [TIME_W-1:0]    w_last;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [PROD_W-1:0] w_shifted;

    // Clamp the entry count and screen degenerate settings
    always_comb begin
        w_accept    = start && !busy;
        w_used      = (r_entries_used > USED_W'(TABLE_DEPTH)) ? USED_W'(TABLE_DEPTH)
                                                               : r_entries_used;
        w_bad_cfg   = (w_used < USED_W'(2)) || (r_sample_spacing == '0);
        w_div_start = w_accept && (i_mode == MODE_QUERY) && !w_bad_cfg;
        w_idx       = r_quot[QUOT_W-1:FRAC_BITS];
        w_last      = TIME_W'(w_used) - TIME_W'(1);
        w_diff      = $signed({r_rd_data[DATA_W-1], r_rd_data})
                    - $signed({r_v0[DATA_W-1], r_v0});
        w_shifted   = r_prod >>> FRAC_BITS;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_spacing <= SPACING_RESET;
            r_entries_used   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SAMPLE_SPACING: r_sample_spacing <= i_cfg_data;
                CFG_ENTRIES_USED:   r_entries_used   <= i_cfg_data[USED_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_mode == MODE_WRITE)
                && ({20'b0, i_entry_index} < TIME_W'(TABLE_DEPTH))) begin
            r_table[ADDR_W'(i_entry_index)] <= i_entry_value;
        end
        r_rd_data <= r_table[r_rd_addr];
    end

    utli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({i_query_time, FRAC_BITS'(0)}),
        .i_divisor  (r_sample_spacing),
        .o_done     (w_div_done),
        .o_quotient (w_div_quot)
    );

    // Sequencer with registered result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_oor    <= 1'b0;
            r_value  <= '0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_mode == MODE_QUERY)) begin
                        if (w_bad_cfg) begin
                            r_strobe <= 1'b1;
                            r_oor    <= 1'b1;
                            r_value  <= '0;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_idx >= w_last) begin
                        r_strobe <= 1'b1;
                        r_oor    <= 1'b1;
                        r_value  <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_RD0;
                    end
                end
                S_RD0:   r_state <= S_RD1;
                S_RD1:   r_state <= S_MUL;
                S_MUL:   r_state <= S_SUM;
                S_SUM: begin
                    r_strobe <= 1'b1;
                    r_oor    <= 1'b0;
                    r_value  <= r_v0 + w_shifted[DATA_W-1:0];
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers: quotient, read addresses, left sample, product
    always_ff @(posedge i_clk) begin
        if (w_div_done) begin
            r_quot <= w_div_quot;
        end
        case (r_state)
            S_CHECK: r_rd_addr <= w_idx[ADDR_W-1:0];
            S_RD0:   r_rd_addr <= r_rd_addr + 1'b1;
            S_RD1:   r_v0      <= r_rd_data;
            S_MUL:   r_prod    <= PROD_W'(w_diff * $signed({1'b0, r_quot[FRAC_BITS-1:0]}));
            default: ;
        endcase
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_out_of_range  = r_oor;
    assign o_kernel_value  = r_value;

    // A result beat leaves the block free for the next item
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !busy)
        else $error("result beat while busy");

    // Out of range results carry a zero value
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_out_of_range) |-> (o_kernel_value == '0))
        else $error("out of range result is not zero");

    // A table write gives no result beat
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode == MODE_WRITE)) |=> !o_result_strobe)
        else $error("table write produced a result");

    // Divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider done outside divide state");

endmodule

### sv/utli_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
module utli_div
    import utli_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [QUOT_W-1:0] i_dividend,
    input  logic [TIME_W-1:0] i_divisor,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [REM_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_quot;
    logic [TIME_W-1:0] r_div;

    logic [REM_W-1:0]  n_shift;
    logic              n_fit;
    logic [REM_W-1:0]  n_rem;

    // Shared compare-subtract step
    always_comb begin
        n_shift = {r_rem[REM_W-2:0], r_quot[QUOT_W-1]};
        n_fit   = (n_shift >= {1'b0, r_div});
        n_rem   = n_fit ? (n_shift - {1'b0, r_div}) : n_shift;
    end

    // Sequence the steps and flag the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift together
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[QUOT_W-2:0], n_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule
